// ===== rtl/klls_pkg.sv =====
// Shared types, codes and reset values for the keypad lock load switch.
package klls_pkg;

    localparam int KEY_W = 4;
    localparam int PASSKEY_W = 16;
    localparam int EVENT_W = 2;
    localparam int CMD_W = 2;

    // register indexes
    localparam logic REG_PASSKEY_ONE = 1'b0;
    localparam logic REG_PASSKEY_TWO = 1'b1;

    localparam logic [PASSKEY_W-1:0] PASSKEY_ONE_RST = 16'h1234;
    localparam logic [PASSKEY_W-1:0] PASSKEY_TWO_RST = 16'h8520;

    // menu modes
    localparam logic [1:0] MODE_MAIN   = 2'd0;
    localparam logic [1:0] MODE_SELECT = 2'd1;
    localparam logic [1:0] MODE_ENTRY  = 2'd2;

    // event codes
    localparam logic [EVENT_W-1:0] EV_STEP   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_STATUS = 2'd1;
    localparam logic [EVENT_W-1:0] EV_RIGHT  = 2'd2;
    localparam logic [EVENT_W-1:0] EV_WRONG  = 2'd3;

    // menu keys
    localparam logic [KEY_W-1:0] KEY_ONE = 4'd1;
    localparam logic [KEY_W-1:0] KEY_TWO = 4'd2;

    localparam logic [1:0] LAST_DIGIT = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic       chosen;
        logic [1:0] digits;
        logic       mismatch;
        logic       load_two;
        logic       load_one;
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic               load_two_on;
        logic               load_one_on;
        logic [EVENT_W-1:0] event_res;
    } t_result;

    localparam t_state STATE_RST = '{
        mode: MODE_MAIN, chosen: 1'b0, digits: 2'd0, mismatch: 1'b0,
        load_two: 1'b0, load_one: 1'b0
    };

endpackage

// ===== rtl/klls_step.sv =====
// Next-state and result logic for one key press.
module klls_step (
    input  klls_pkg::t_state                   i_state,
    input  logic [klls_pkg::KEY_W-1:0]         i_key,
    input  logic [klls_pkg::PASSKEY_W-1:0]     i_passkey_one,
    input  logic [klls_pkg::PASSKEY_W-1:0]     i_passkey_two,
    output klls_pkg::t_state                   o_state,
    output klls_pkg::t_result                  o_result
);

    logic [klls_pkg::PASSKEY_W-1:0] w_pk;
    logic [klls_pkg::KEY_W-1:0]     w_want;
    logic                           w_miss;

    assign w_pk = i_state.chosen ? i_passkey_two : i_passkey_one;

    // first key sits in the top nibble
    always_comb begin
        case (i_state.digits)
            2'd0:    w_want = w_pk[15:12];
            2'd1:    w_want = w_pk[11:8];
            2'd2:    w_want = w_pk[7:4];
            default: w_want = w_pk[3:0];
        endcase
    end

    assign w_miss = i_state.mismatch || (i_key != w_want);

    always_comb begin
        o_state            = i_state;
        o_result.event_res = klls_pkg::EV_STEP;
        o_result.command   = '0;
        unique case (i_state.mode)
            klls_pkg::MODE_SELECT: begin
                if (i_key == klls_pkg::KEY_ONE || i_key == klls_pkg::KEY_TWO) begin
                    o_state.chosen   = (i_key == klls_pkg::KEY_TWO);
                    o_state.digits   = 2'd0;
                    o_state.mismatch = 1'b0;
                    o_state.mode     = klls_pkg::MODE_ENTRY;
                end else begin
                    o_state.mode = klls_pkg::MODE_MAIN;
                end
            end
            klls_pkg::MODE_ENTRY: begin
                if (i_state.digits == klls_pkg::LAST_DIGIT) begin
                    if (!w_miss) begin
                        if (i_state.chosen) begin
                            o_state.load_two = ~i_state.load_two;
                        end else begin
                            o_state.load_one = ~i_state.load_one;
                        end
                        o_result.event_res = klls_pkg::EV_RIGHT;
                    end else begin
                        o_result.event_res = klls_pkg::EV_WRONG;
                    end
                    o_state.digits   = 2'd0;
                    o_state.mismatch = 1'b0;
                    o_state.mode     = klls_pkg::MODE_MAIN;
                end else begin
                    o_state.mismatch = w_miss;
                    o_state.digits   = i_state.digits + 2'd1;
                end
            end
            default: begin
                // main menu, and the unused mode
                o_state.mode = klls_pkg::MODE_MAIN;
                if (i_key == klls_pkg::KEY_ONE) begin
                    o_result.event_res = klls_pkg::EV_STATUS;
                end else if (i_key == klls_pkg::KEY_TWO) begin
                    o_state.mode = klls_pkg::MODE_SELECT;
                end
            end
        endcase
        o_result.load_one_on = o_state.load_one;
        o_result.load_two_on = o_state.load_two;
        if (o_result.event_res == klls_pkg::EV_RIGHT) begin
            o_result.command = {o_state.load_two, o_state.load_one};
        end
    end

endmodule

// ===== rtl/keypad_lock_load_switch_core.sv =====
// Top level of the keypad lock load switch: handshakes, state and result registers.
// One request carries one decoded key press and yields exactly one result. A key is
// captured in an input register, run through the menu logic and lands in a result
// register; a new key is taken every cycle for as long as results are drained, and
// when the result register is full and stalled the input register holds and
// s_axis_tready drops. Passkeys are written on the config port (index 0 load one,
// index 1 load two); the user must write them only while the block is idle, which the
// block itself does not enforce. The load bits start off after reset.
module keypad_lock_load_switch_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // key press in
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [3:0] key_code, [7:4] zero
    // result out
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [1:0] event_res, [2] load_one_on,
                                       // [3] load_two_on, [5:4] command, [7:6] zero
    // passkey writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [klls_pkg::PASSKEY_W-1:0] r_passkey_one;
    logic [klls_pkg::PASSKEY_W-1:0] r_passkey_two;
    klls_pkg::t_state               r_state;
    klls_pkg::t_state               n_state;
    klls_pkg::t_result              n_result;
    klls_pkg::t_result              r_out;
    logic                           r_out_valid;
    logic                           r_in_valid;
    logic [klls_pkg::KEY_W-1:0]     r_in_key;
    logic                           w_adv;

    // input stage moves on when the result slot is free or being emptied
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_passkey_one <= klls_pkg::PASSKEY_ONE_RST;
            r_passkey_two <= klls_pkg::PASSKEY_TWO_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == klls_pkg::REG_PASSKEY_ONE) begin
                r_passkey_one <= i_cfg_data;
            end else begin
                r_passkey_two <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_key <= s_axis_tdata[klls_pkg::KEY_W-1:0];
        end
    end

    klls_step u_step (
        .i_state       (r_state),
        .i_key         (r_in_key),
        .i_passkey_one (r_passkey_one),
        .i_passkey_two (r_passkey_two),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= klls_pkg::STATE_RST;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

    // a command is only ever issued with a right passkey, and it mirrors the loads
    a_cmd_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == klls_pkg::EV_RIGHT)
            |-> (r_out.command == {r_out.load_two_on, r_out.load_one_on}))
        else $error("command does not match load bits");

    a_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res != klls_pkg::EV_RIGHT) |-> (r_out.command == '0))
        else $error("command issued without a right passkey");

    // the load bits only change on a right passkey
    a_load_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_state.load_one != $past(r_state.load_one)
            || r_state.load_two != $past(r_state.load_two)))
            |-> $past(w_adv && n_result.event_res == klls_pkg::EV_RIGHT))
        else $error("load bit changed outside a right passkey");

    // a partial entry exists only in passkey entry mode
    a_digits_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.digits != 2'd0) |-> (r_state.mode == klls_pkg::MODE_ENTRY))
        else $error("digit count outside passkey entry");

endmodule

// ===== verif/keypad_lock_load_switch_core_tb.sv =====
// Self-checking testbench for the keypad lock load switch core.
`timescale 1ns / 1ps

module keypad_lock_load_switch_core_tb;

    // Worst case per request: the longest sender gap plus the longest result stall
    // plus pipeline latency, for about 1650 requests; the limit leaves a wide
    // margin on top of that.
    localparam int CYCLE_LIMIT = 600_000;
    localparam int N_DIRECTED = 24;
    localparam int N_PER_PHASE = 400;
    localparam int DRAIN_CYCLES = 6;     // settling after the last owed result has come back

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        logic [klls_pkg::KEY_W-1:0] key;
        logic                       typed;
        klls_pkg::t_result          res;
    } t_key_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;     // [3:0] key_code, [7:4] zero
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;     // [1:0] event_res, [2] load_one_on,
                                         // [3] load_two_on, [5:4] command, [7:6] zero
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_index;
    logic [15:0]       i_cfg_data;

    // predictor copy of the lock: menu state and both passkeys
    klls_pkg::t_state               lock_st;
    logic [klls_pkg::PASSKEY_W-1:0] lock_pk [2];

    t_key_row          pending_rows [$];     // driven requests, oldest first
    klls_pkg::t_result pending_results [$];  // results still owed by the block

    int  keys_taken;
    int  cfg_taken;
    int  cycle_count;
    int  n_faults;
    bit  fast_phase;                 // no idling on either side when set

    keypad_lock_load_switch_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor: one key press in, one result out, state moves on.
    // ---------------------------------------------------------------
    function automatic klls_pkg::t_result lock_response(
            input logic [klls_pkg::KEY_W-1:0] key);
        klls_pkg::t_result              r;
        logic [klls_pkg::PASSKEY_W-1:0] pk;
        logic [klls_pkg::KEY_W-1:0]     want;
        r = '0;
        r.event_res = klls_pkg::EV_STEP;
        case (lock_st.mode)
            klls_pkg::MODE_SELECT: begin
                if (key == klls_pkg::KEY_ONE || key == klls_pkg::KEY_TWO) begin
                    lock_st.chosen   = (key == klls_pkg::KEY_TWO);
                    lock_st.digits   = 2'd0;
                    lock_st.mismatch = 1'b0;
                    lock_st.mode     = klls_pkg::MODE_ENTRY;
                end else begin
                    lock_st.mode = klls_pkg::MODE_MAIN;
                end
            end
            klls_pkg::MODE_ENTRY: begin
                pk   = lock_st.chosen ? lock_pk[klls_pkg::REG_PASSKEY_TWO]
                                      : lock_pk[klls_pkg::REG_PASSKEY_ONE];
                // first key sits in the top nibble
                want = pk[15 - 4*lock_st.digits -: 4];
                if (key != want)
                    lock_st.mismatch = 1'b1;
                if (lock_st.digits == klls_pkg::LAST_DIGIT) begin
                    if (!lock_st.mismatch) begin
                        if (lock_st.chosen)
                            lock_st.load_two = ~lock_st.load_two;
                        else
                            lock_st.load_one = ~lock_st.load_one;
                        r.command   = {lock_st.load_two, lock_st.load_one};
                        r.event_res = klls_pkg::EV_RIGHT;
                    end else begin
                        r.event_res = klls_pkg::EV_WRONG;
                    end
                    lock_st.digits   = 2'd0;
                    lock_st.mismatch = 1'b0;
                    lock_st.mode     = klls_pkg::MODE_MAIN;
                end else begin
                    lock_st.digits = lock_st.digits + 2'd1;
                end
            end
            default: begin
                // main menu, and the unused fourth mode alike
                lock_st.mode = klls_pkg::MODE_MAIN;
                if (key == klls_pkg::KEY_ONE)
                    r.event_res = klls_pkg::EV_STATUS;
                else if (key == klls_pkg::KEY_TWO)
                    lock_st.mode = klls_pkg::MODE_SELECT;
            end
        endcase
        r.load_one_on = lock_st.load_one;
        r.load_two_on = lock_st.load_two;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Directed table.  Reset passkeys: load one 1234, load two 8520.
    // ---------------------------------------------------------------
    function automatic t_key_row row(input logic [klls_pkg::KEY_W-1:0] key,
                                     input logic typed,
                                     input logic [klls_pkg::EVENT_W-1:0] ev,
                                     input logic l1, input logic l2,
                                     input logic [klls_pkg::CMD_W-1:0] cmd);
        t_key_row k;
        k.key               = key;
        k.typed             = typed;
        k.res.event_res     = ev;
        k.res.load_one_on   = l1;
        k.res.load_two_on   = l2;
        k.res.command       = cmd;
        return k;
    endfunction

    function automatic t_key_row directed_row(input int i);
        case (i)
            // status straight after reset: both loads off
            0:  return row(klls_pkg::KEY_ONE, 1'b1, klls_pkg::EV_STATUS, 1'b0, 1'b0, 2'd0);
            // other keys in the main menu, lowest and highest code
            1:  return row(4'd0,    1'b1, klls_pkg::EV_STEP,   1'b0, 1'b0, 2'd0);
            2:  return row(4'd15,   1'b1, klls_pkg::EV_STEP,   1'b0, 1'b0, 2'd0);
            // open selection, pick load one, right passkey
            3:  return row(klls_pkg::KEY_TWO, 1'b0, klls_pkg::EV_STEP, 1'b0, 1'b0, 2'd0);
            4:  return row(klls_pkg::KEY_ONE, 1'b0, klls_pkg::EV_STEP, 1'b0, 1'b0, 2'd0);
            5:  return row(4'd1,    1'b0, klls_pkg::EV_STEP,   1'b0, 1'b0, 2'd0);
            6:  return row(4'd2,    1'b0, klls_pkg::EV_STEP,   1'b0, 1'b0, 2'd0);
            7:  return row(4'd3,    1'b0, klls_pkg::EV_STEP,   1'b0, 1'b0, 2'd0);
            8:  return row(4'd4,    1'b1, klls_pkg::EV_RIGHT,  1'b1, 1'b0, 2'b01);
            // status with load one on
            9:  return row(klls_pkg::KEY_ONE, 1'b1, klls_pkg::EV_STATUS, 1'b1, 1'b0, 2'd0);
            // load two, right passkey: both on
            10: return row(klls_pkg::KEY_TWO, 1'b0, klls_pkg::EV_STEP, 1'b0, 1'b0, 2'd0);
            11: return row(klls_pkg::KEY_TWO, 1'b0, klls_pkg::EV_STEP, 1'b0, 1'b0, 2'd0);
            12: return row(4'd8,    1'b0, klls_pkg::EV_STEP,   1'b0, 1'b0, 2'd0);
            13: return row(4'd5,    1'b0, klls_pkg::EV_STEP,   1'b0, 1'b0, 2'd0);
            14: return row(4'd2,    1'b0, klls_pkg::EV_STEP,   1'b0, 1'b0, 2'd0);
            15: return row(4'd0,    1'b1, klls_pkg::EV_RIGHT,  1'b1, 1'b1, 2'b11);
            // load two, last key wrong: no toggle, command zero
            16: return row(klls_pkg::KEY_TWO, 1'b0, klls_pkg::EV_STEP, 1'b0, 1'b0, 2'd0);
            17: return row(klls_pkg::KEY_TWO, 1'b0, klls_pkg::EV_STEP, 1'b0, 1'b0, 2'd0);
            18: return row(4'd8,    1'b0, klls_pkg::EV_STEP,   1'b0, 1'b0, 2'd0);
            19: return row(4'd5,    1'b0, klls_pkg::EV_STEP,   1'b0, 1'b0, 2'd0);
            20: return row(4'd2,    1'b0, klls_pkg::EV_STEP,   1'b0, 1'b0, 2'd0);
            21: return row(4'd1,    1'b1, klls_pkg::EV_WRONG,  1'b1, 1'b1, 2'd0);
            // non-load key in selection drops back to main menu
            22: return row(klls_pkg::KEY_TWO, 1'b0, klls_pkg::EV_STEP, 1'b0, 1'b0, 2'd0);
            default: return row(4'd13, 1'b1, klls_pkg::EV_STEP, 1'b1, 1'b1, 2'd0);
        endcase
    endfunction

    // sender gap: mostly none or short, now and then long
    function automatic int key_gap();
        int r;
        if (fast_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // ---------------------------------------------------------------
    // Sender side.  Called and returning at a falling edge.
    // ---------------------------------------------------------------
    task automatic send_key(input t_key_row k);
        int gap;
        int target;
        gap    = key_gap();
        target = keys_taken + 1;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pending_rows.push_back(k);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, k.key};
        do @(negedge i_clk); while (keys_taken < target);
    endtask

    task automatic send_free_key(input logic [klls_pkg::KEY_W-1:0] key);
        send_key(row(key, 1'b0, klls_pkg::EV_STEP, 1'b0, 1'b0, 2'd0));
    endtask

    // valid drops for a cycle after each write
    task automatic write_passkey(input logic idx, input logic [15:0] value);
        int target;
        target = cfg_taken + 1;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (cfg_taken < target);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // lower valid, let every owed result come back, then settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Mostly well-formed entries (select, load, four keys) with random content,
    // plus status requests and free noise keys that can knock the menu off track.
    task automatic random_phase(input int n_items);
        int                             sent;
        int                             r;
        int                             d;
        logic                           load;
        logic                           exact;
        logic [klls_pkg::KEY_W-1:0]     nib;
        logic [klls_pkg::PASSKEY_W-1:0] pk;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                load = 1'($urandom_range(0, 1));
                pk   = lock_pk[load];
                send_free_key(klls_pkg::KEY_TWO);
                // a broken selection now and then
                if ($urandom_range(0, 99) < 8)
                    send_free_key(4'($urandom_range(0, 15)));
                else
                    send_free_key(load ? klls_pkg::KEY_TWO : klls_pkg::KEY_ONE);
                exact = 1'($urandom_range(0, 1));
                for (d = 0; d < 4; d++) begin
                    nib = pk[15 - 4*d -: 4];
                    if (!exact && $urandom_range(0, 3) == 0)
                        nib = 4'($urandom_range(0, 15));
                    send_free_key(nib);
                end
                sent += 6;
            end else if (r < 85) begin
                send_free_key(klls_pkg::KEY_ONE);
                sent++;
            end else begin
                send_free_key(4'($urandom_range(0, 15)));
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver stall pattern.  No stall and no ready spell is empty, so
    // that ready never gets two updates at the same edge.
    // ---------------------------------------------------------------
    initial begin
        int hold;
        int r;
        m_axis_tready = 1'b1;
        @(negedge i_clk);
        forever begin
            if (fast_phase) begin
                m_axis_tready <= 1'b1;
                @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                hold = $urandom_range(1, 12);
                repeat (hold) @(negedge i_clk);
                r = $urandom_range(0, 99);
                if (r < 60)
                    hold = $urandom_range(1, 2);
                else if (r < 92)
                    hold = $urandom_range(3, 6);
                else
                    hold = $urandom_range(10, 40);
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // Rising edge: take accepted requests into the predictor, check
    // accepted results against the oldest expectation, keep the clock.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_key_row          k;
        klls_pkg::t_result want;
        klls_pkg::t_result got;
        klls_pkg::t_result pred;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = klls_pkg::t_result'(m_axis_tdata[5:0]);
                if (pending_results.size() == 0) begin
                    $error("result with nothing owed: tdata %h", m_axis_tdata);
                    n_faults++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.event_res !== want.event_res) begin
                        $error("event_res: expected %0d, got %0d", want.event_res,
                               got.event_res);
                        n_faults++;
                    end
                    if (got.load_one_on !== want.load_one_on) begin
                        $error("load_one_on: expected %0d, got %0d", want.load_one_on,
                               got.load_one_on);
                        n_faults++;
                    end
                    if (got.load_two_on !== want.load_two_on) begin
                        $error("load_two_on: expected %0d, got %0d", want.load_two_on,
                               got.load_two_on);
                        n_faults++;
                    end
                    if (got.command !== want.command) begin
                        $error("command: expected %0d, got %0d", want.command, got.command);
                        n_faults++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                k    = pending_rows.pop_front();
                pred = lock_response(s_axis_tdata[3:0]);
                // typed rows are checked against the hand-written result
                pending_results.push_back(k.typed ? k.res : pred);
                keys_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                lock_pk[i_cfg_index] = i_cfg_data;
                cfg_taken++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence: reset, directed table, then four random phases
    // with passkeys rewritten in between (extremes first).
    // ---------------------------------------------------------------
    initial begin
        int i;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = klls_pkg::REG_PASSKEY_ONE;
        i_cfg_data    = '0;
        fast_phase    = 1'b0;
        keys_taken    = 0;
        cfg_taken     = 0;
        cycle_count   = 0;
        n_faults      = 0;
        lock_st       = klls_pkg::STATE_RST;
        lock_pk[klls_pkg::REG_PASSKEY_ONE] = klls_pkg::PASSKEY_ONE_RST;
        lock_pk[klls_pkg::REG_PASSKEY_TWO] = klls_pkg::PASSKEY_TWO_RST;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (i = 0; i < N_DIRECTED; i++)
            send_key(directed_row(i));
        drain();

        // all-zero and all-ones passkeys
        write_passkey(klls_pkg::REG_PASSKEY_ONE, 16'h0000);
        write_passkey(klls_pkg::REG_PASSKEY_TWO, 16'hFFFF);
        random_phase(N_PER_PHASE);
        drain();

        // swapped extremes, no idling on either side
        fast_phase = 1'b1;
        write_passkey(klls_pkg::REG_PASSKEY_ONE, 16'hFFFF);
        write_passkey(klls_pkg::REG_PASSKEY_TWO, 16'h0000);
        random_phase(N_PER_PHASE);
        drain();
        fast_phase = 1'b0;

        repeat (2) begin
            write_passkey(klls_pkg::REG_PASSKEY_ONE, 16'($urandom_range(0, 65535)));
            write_passkey(klls_pkg::REG_PASSKEY_TWO, 16'($urandom_range(0, 65535)));
            random_phase(N_PER_PHASE);
            drain();
        end

        if (n_faults == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/klls_pkg.sv
rtl/klls_step.sv
rtl/keypad_lock_load_switch_core.sv
verif/keypad_lock_load_switch_core_tb.sv
